>>> rtl/aod_pkg.sv
`timescale 1ns / 1ps

package aod_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int THRESH_BITS = 15;
    localparam int WINDOW_BITS = 8;
    localparam int COUNT_BITS  = 4;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;
    localparam int NUM_AXES    = 2;

    // compare width holds the signed angle, the threshold and its negation
    localparam int CMP_BITS = ((ANGLE_BITS > THRESH_BITS) ? ANGLE_BITS : THRESH_BITS) + 2;
    // count arithmetic spans -2 .. limit + 1
    localparam int SUM_BITS = COUNT_BITS + 2;

    localparam int AXIS_PITCH = 0;
    localparam int AXIS_ROLL  = 1;

    localparam logic [1:0] REG_ANGLE_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_PITCH_WINDOW    = 2'd1;
    localparam logic [1:0] REG_ROLL_WINDOW     = 2'd2;
    localparam logic [1:0] REG_COUNT_LIMIT     = 2'd3;

    localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET    = THRESH_BITS'(1200);
    localparam logic [WINDOW_BITS-1:0] PITCH_WINDOW_RESET = WINDOW_BITS'(60);
    localparam logic [WINDOW_BITS-1:0] ROLL_WINDOW_RESET  = WINDOW_BITS'(40);
    localparam logic [COUNT_BITS-1:0]  COUNT_LIMIT_RESET  = COUNT_BITS'(8);

    typedef enum logic {
        AXIS_IDLE,
        AXIS_ARMED
    } axis_state_t;

endpackage

>>> rtl/attitude_oscillation_detector.sv
`timescale 1ns / 1ps

// Attitude oscillation detector.
// Sample channel: pitch_angle, roll_angle and clear_request, moved by
// sample_valid / sample_stall; one request is one sample tick.
// Result channel: error_flag, pitch_count, roll_count, moved by
// result_valid / result_stall; exactly one result per sample.
// A sample accepted into the input register moves into the result register
// when it advances (the result register is empty or the receiver is not
// stalling), and result_valid is registered together with that result.
// Throughput: one sample per cycle while the receiver does not stall; per-axis
// state is updated as a sample passes from the input register into the result
// register, so the next sample always sees the state left by the one before it.
// When the receiver stalls, the result register holds and the input register
// keeps taking one more sample; after that sample_stall rises until the
// result is taken.
// Reset clears both axes to idle, zeroes counts, tick counters and the error
// flag, empties both registers, and loads the register defaults
// (threshold 1200, pitch window 60, roll window 40, count limit 8).
// Registers sit on the APB port at byte addresses 0, 4, 8 and 12.
module attitude_oscillation_detector
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [aod_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [aod_pkg::DATA_BITS-1:0]         pwdata,
    output logic [aod_pkg::DATA_BITS-1:0]         prdata,
    output logic                                  pready,

    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic signed [aod_pkg::ANGLE_BITS-1:0] pitch_angle,
    input  logic signed [aod_pkg::ANGLE_BITS-1:0] roll_angle,
    input  logic                                  clear_request,

    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic                                  error_flag,
    output logic [aod_pkg::COUNT_BITS-1:0]        pitch_count,
    output logic [aod_pkg::COUNT_BITS-1:0]        roll_count
);

    localparam int NA = aod_pkg::NUM_AXES;

    // configuration
    logic [aod_pkg::THRESH_BITS-1:0] threshold_reg;
    logic [aod_pkg::WINDOW_BITS-1:0] pitch_window_reg;
    logic [aod_pkg::WINDOW_BITS-1:0] roll_window_reg;
    logic [aod_pkg::COUNT_BITS-1:0]  limit_reg;
    logic                            cfg_write;
    logic [1:0]                      cfg_sel;

    // input register
    logic                                  in_valid_reg;
    logic signed [aod_pkg::ANGLE_BITS-1:0] sample_angle_reg [NA];
    logic                                  clear_reg;

    // result register
    logic                           out_valid_reg;
    logic                           out_error_reg;
    logic [aod_pkg::COUNT_BITS-1:0] out_count_reg [NA];

    // axis state
    aod_pkg::axis_state_t            state_reg [NA];
    aod_pkg::axis_state_t            state_next [NA];
    logic                            positive_reg [NA];
    logic                            positive_next [NA];
    logic [aod_pkg::WINDOW_BITS-1:0] tick_reg [NA];
    logic [aod_pkg::WINDOW_BITS-1:0] tick_next [NA];
    logic [aod_pkg::COUNT_BITS-1:0]  count_reg [NA];
    logic [aod_pkg::COUNT_BITS-1:0]  count_next [NA];
    logic                            error_reg;
    logic                            error_next;

    // per-axis decode
    logic [aod_pkg::WINDOW_BITS-1:0] window [NA];
    logic                            above_pos [NA];
    logic                            below_neg [NA];
    logic                            timeout [NA];
    logic                            reversal [NA];

    logic advance;
    logic load_in;

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign cfg_sel   = paddr[3:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (cfg_sel)
            aod_pkg::REG_ANGLE_THRESHOLD: prdata = aod_pkg::DATA_BITS'(threshold_reg);
            aod_pkg::REG_PITCH_WINDOW:    prdata = aod_pkg::DATA_BITS'(pitch_window_reg);
            aod_pkg::REG_ROLL_WINDOW:     prdata = aod_pkg::DATA_BITS'(roll_window_reg);
            aod_pkg::REG_COUNT_LIMIT:     prdata = aod_pkg::DATA_BITS'(limit_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= aod_pkg::THRESHOLD_RESET;
            pitch_window_reg <= aod_pkg::PITCH_WINDOW_RESET;
            roll_window_reg  <= aod_pkg::ROLL_WINDOW_RESET;
            limit_reg        <= aod_pkg::COUNT_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                aod_pkg::REG_ANGLE_THRESHOLD:
                    threshold_reg <= pwdata[aod_pkg::THRESH_BITS-1:0];
                aod_pkg::REG_PITCH_WINDOW:
                    pitch_window_reg <= pwdata[aod_pkg::WINDOW_BITS-1:0];
                aod_pkg::REG_ROLL_WINDOW:
                    roll_window_reg <= pwdata[aod_pkg::WINDOW_BITS-1:0];
                aod_pkg::REG_COUNT_LIMIT:
                    limit_reg <= pwdata[aod_pkg::COUNT_BITS-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    assign advance      = in_valid_reg & (~out_valid_reg | ~result_stall);
    assign load_in      = ~in_valid_reg | advance;
    assign sample_stall = ~load_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_in)
                in_valid_reg <= sample_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (~result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in & sample_valid)
        begin
            sample_angle_reg[aod_pkg::AXIS_PITCH] <= pitch_angle;
            sample_angle_reg[aod_pkg::AXIS_ROLL]  <= roll_angle;
            clear_reg                             <= clear_request;
        end
    end

    // ---------------------------------------------------------------- axis decode
    assign window[aod_pkg::AXIS_PITCH] = pitch_window_reg;
    assign window[aod_pkg::AXIS_ROLL]  = roll_window_reg;

    always_comb
    begin
        logic signed [aod_pkg::CMP_BITS-1:0] a_ext;
        logic signed [aod_pkg::CMP_BITS-1:0] thr_ext;
        thr_ext = signed'(aod_pkg::CMP_BITS'(threshold_reg));
        for (int i = 0; i < NA; i++)
        begin
            a_ext        = aod_pkg::CMP_BITS'(sample_angle_reg[i]);
            above_pos[i] = a_ext > thr_ext;
            below_neg[i] = a_ext < -thr_ext;
            // timeout wins over a reversal on the same tick
            timeout[i]   = tick_reg[i] > window[i];
            reversal[i]  = positive_reg[i] ? below_neg[i] : above_pos[i];
        end
    end

    // next state
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            state_next[i] = state_reg[i];
            unique case (state_reg[i])
                aod_pkg::AXIS_IDLE:
                    if (above_pos[i] | below_neg[i])
                        state_next[i] = aod_pkg::AXIS_ARMED;
                aod_pkg::AXIS_ARMED:
                    if (timeout[i] | reversal[i])
                        state_next[i] = aod_pkg::AXIS_IDLE;
            endcase
        end
    end

    // datapath updates per state
    always_comb
    begin
        logic [aod_pkg::COUNT_BITS-1:0]      base;
        logic signed [aod_pkg::SUM_BITS-1:0] delta;
        logic signed [aod_pkg::SUM_BITS-1:0] sum;
        logic                                hit;
        hit = 1'b0;
        for (int i = 0; i < NA; i++)
        begin
            positive_next[i] = positive_reg[i];
            tick_next[i]     = tick_reg[i];
            delta            = '0;
            unique case (state_reg[i])
                aod_pkg::AXIS_IDLE:
                    if (above_pos[i] | below_neg[i])
                    begin
                        positive_next[i] = above_pos[i];
                        tick_next[i]     = '0;
                    end
                aod_pkg::AXIS_ARMED:
                begin
                    tick_next[i] = tick_reg[i] + 1'b1;
                    if (timeout[i])
                        delta = -aod_pkg::SUM_BITS'(2);
                    else if (reversal[i])
                        delta = aod_pkg::SUM_BITS'(1);
                end
            endcase
            base = clear_reg ? '0 : count_reg[i];
            sum  = signed'(aod_pkg::SUM_BITS'(base)) + delta;
            if (sum[aod_pkg::SUM_BITS-1])
                count_next[i] = '0;
            else if (sum[aod_pkg::SUM_BITS-2:0] > (aod_pkg::SUM_BITS-1)'(limit_reg))
                count_next[i] = limit_reg;
            else
                count_next[i] = sum[aod_pkg::COUNT_BITS-1:0];
            hit = hit | (count_next[i] >= limit_reg);
        end
        error_next = (error_reg & ~clear_reg) | hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NA; i++)
            begin
                state_reg[i]    <= aod_pkg::AXIS_IDLE;
                positive_reg[i] <= 1'b0;
                tick_reg[i]     <= '0;
                count_reg[i]    <= '0;
            end
            error_reg <= 1'b0;
        end
        else if (advance)
        begin
            for (int i = 0; i < NA; i++)
            begin
                state_reg[i]    <= state_next[i];
                positive_reg[i] <= positive_next[i];
                tick_reg[i]     <= tick_next[i];
                count_reg[i]    <= count_next[i];
            end
            error_reg <= error_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_error_reg <= error_next;
            for (int i = 0; i < NA; i++)
                out_count_reg[i] <= count_next[i];
        end
    end

    assign result_valid = out_valid_reg;
    assign error_flag   = out_error_reg;
    assign pitch_count  = out_count_reg[aod_pkg::AXIS_PITCH];
    assign roll_count   = out_count_reg[aod_pkg::AXIS_ROLL];

endmodule
